/* rtl/core/lhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

  // record kinds
  localparam logic [1:0] KIND_CCI      = 2'd0;
  localparam logic [1:0] KIND_EXT      = 2'd1;
  localparam logic [1:0] KIND_EXT_LAST = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  // header-end status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERRUN  = 2'd3;

  // extension types from here up are fixed length
  localparam logic [7:0] EXT_FIXED_MIN = 8'd128;
  localparam logic [9:0] EXT_FIXED_LEN = 10'd3;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } lhp_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  out_byte;
    logic [7:0]  ext_type;
    logic [3:0]  version;
    logic [1:0]  psi_bits;
    logic [7:0]  code_point;
    logic [47:0] session_id;
    logic [63:0] object_id_low;
    logic [47:0] object_id_high;
    logic [1:0]  close_flags;
    logic [1:0]  status;
    logic        last_of_run;
  } lhp_out_t;

  // up to two results per byte, second only ever a header-end record
  typedef struct packed {
    logic     push0;
    logic     push1;
    lhp_out_t rec0;
    lhp_out_t rec1;
  } lhp_push_t;

endpackage

`default_nettype wire

/* rtl/core/lct_header_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// LCT header parser. Takes one datagram byte per beat and can accept a byte in
// every cycle while the result queue has room; each byte gives zero, one or two
// result beats (a CCI or extension byte record, a header-end or error record,
// or a byte record followed by the end record). An input beat passes through a
// one-entry input register, then the parse stage that updates the header state
// and writes its results into a four-entry result queue drained one beat per
// cycle unless the output stalls. The input stalls while the queue holds more
// than two results, so the sustained rate is one byte per cycle whenever results
// average one per byte or fewer and the output does not stall.
module lct_header_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lhp_pkg::lhp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lhp_pkg::lhp_out_t      out_data_o
);

  logic               in_valid_q, in_valid_d;
  lhp_pkg::lhp_in_t   in_q;
  logic               space_ok, go, in_accept;
  lhp_pkg::lhp_push_t push;

  assign go         = in_valid_q && space_ok;
  assign in_stall_o = in_valid_q && !space_ok;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_q <= in_data_i;
  end

  lhp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (go),
    .item_i       (in_q),
    .push_o       (push)
  );

  lhp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/core/lhp_parse.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhp_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  input  wire lhp_pkg::lhp_in_t  item_i,
  output lhp_pkg::lhp_push_t     push_o
);

  localparam logic [2:0] PH_WORD = 3'd1;
  localparam logic [2:0] PH_CCI  = 3'd2;
  localparam logic [2:0] PH_TSI  = 3'd3;
  localparam logic [2:0] PH_TOI  = 3'd4;
  localparam logic [2:0] PH_EXT  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;
  localparam logic [2:0] PH_ERR  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [9:0]  byte_index_q, byte_index_d;
  logic [9:0]  header_q, header_d;
  logic [4:0]  cci_q, cci_d;
  logic [2:0]  session_q, session_d;
  logic [3:0]  object_q, object_d;
  logic [47:0] sess_acc_q, sess_acc_d;
  logic [63:0] obj_low_q, obj_low_d;
  logic [47:0] obj_high_q, obj_high_d;
  logic [7:0]  ext_type_q, ext_type_d;
  logic [9:0]  ext_rem_q, ext_rem_d;
  logic [15:0] fixed_q, fixed_d;
  logic        need_len_q, need_len_d;
  logic [1:0]  err_q, err_d;

  always_comb begin
    logic [7:0]  b;
    logic [9:0]  idx;
    logic [9:0]  need;
    logic [9:0]  hel;
    logic [10:0] left;
    logic        has_byte, has_end, hdr_end, do_enter;
    logic [1:0]  byte_kind, end_status;
    logic [7:0]  byte_type;
    lhp_pkg::lhp_out_t rec_byte, rec_end;

    b          = item_i.data_byte;
    idx        = (byte_index_q == '1) ? byte_index_q : byte_index_q + 10'd1;
    need       = 10'd4 + 10'(cci_q) + 10'(session_q) + 10'(object_q);
    hel        = {b, 2'b00};
    left       = {1'b0, header_q} + 11'd2 - {1'b0, idx};
    has_byte   = 1'b0;
    hdr_end    = 1'b0;
    do_enter   = 1'b0;
    byte_kind  = lhp_pkg::KIND_CCI;
    byte_type  = 8'd0;

    phase_d      = phase_q;
    byte_index_d = idx;
    header_d     = header_q;
    cci_d        = cci_q;
    session_d    = session_q;
    object_d     = object_q;
    sess_acc_d   = sess_acc_q;
    obj_low_d    = obj_low_q;
    obj_high_d   = obj_high_q;
    ext_type_d   = ext_type_q;
    ext_rem_d    = ext_rem_q;
    fixed_d      = fixed_q;
    need_len_d   = need_len_q;
    err_d        = err_q;

    unique case (phase_q)
      PH_WORD: begin
        priority if (idx == 10'd1) begin
          fixed_d = {b[7:4], b[1:0], 10'd0};
          cci_d   = {1'b0, b[3:2], 2'b00} + 5'd4;
        end else if (idx == 10'd2) begin
          session_d     = {b[7], b[4], 1'b0};
          object_d      = {b[6:5], b[4], 1'b0};
          fixed_d[9:8]  = b[1:0];
        end else if (idx == 10'd3) begin
          header_d = {b, 2'b00};
        end else begin
          fixed_d[7:0] = b;
          if (header_q < need) begin
            err_d   = lhp_pkg::ST_OVERFLOW;
            phase_d = PH_ERR;
          end else begin
            phase_d = PH_CCI;
          end
        end
      end
      PH_CCI: begin
        has_byte = 1'b1;
        cci_d    = cci_q - 5'd1;
        if (cci_d == 5'd0) begin
          if (session_q != 3'd0) phase_d = PH_TSI;
          else if (object_q != 4'd0) phase_d = PH_TOI;
          else do_enter = 1'b1;
        end
      end
      PH_TSI: begin
        sess_acc_d = {sess_acc_q[39:0], b};
        session_d  = session_q - 3'd1;
        if (session_d == 3'd0) begin
          if (object_q != 4'd0) phase_d = PH_TOI;
          else do_enter = 1'b1;
        end
      end
      PH_TOI: begin
        obj_high_d = {obj_high_q[39:0], obj_low_q[63:56]};
        obj_low_d  = {obj_low_q[55:0], b};
        object_d   = object_q - 4'd1;
        if (object_d == 4'd0) do_enter = 1'b1;
      end
      PH_EXT: begin
        priority if (need_len_q) begin
          need_len_d = 1'b0;
          // zero length would never advance, so it counts as an overrun
          if (hel == 10'd0 || {1'b0, hel} > left) begin
            err_d   = lhp_pkg::ST_OVERRUN;
            phase_d = PH_ERR;
          end else begin
            ext_rem_d = hel - 10'd2;
          end
        end else if (ext_rem_q == 10'd0) begin
          ext_type_d = b;
          if (b >= lhp_pkg::EXT_FIXED_MIN) ext_rem_d = lhp_pkg::EXT_FIXED_LEN;
          else need_len_d = 1'b1;
        end else begin
          ext_rem_d = ext_rem_q - 10'd1;
          has_byte  = 1'b1;
          byte_type = ext_type_q;
          byte_kind = (ext_rem_d == 10'd0) ? lhp_pkg::KIND_EXT_LAST : lhp_pkg::KIND_EXT;
          if (ext_rem_d == 10'd0 && idx >= header_q) begin
            phase_d = PH_DONE;
            hdr_end = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_enter) begin
      ext_rem_d  = 10'd0;
      need_len_d = 1'b0;
      if (idx >= header_q) begin
        phase_d = PH_DONE;
        hdr_end = 1'b1;
      end else begin
        phase_d = PH_EXT;
      end
    end

    has_end = hdr_end || (item_i.packet_end && phase_d != PH_DONE);
    if (hdr_end) end_status = lhp_pkg::ST_OK;
    else if (phase_d == PH_ERR)
      end_status = (idx < 10'd4 || idx < header_d) ? lhp_pkg::ST_SHORT : err_d;
    else end_status = lhp_pkg::ST_SHORT;

    rec_byte             = '0;
    rec_byte.record_kind = byte_kind;
    rec_byte.out_byte    = b;
    rec_byte.ext_type    = byte_type;
    rec_byte.last_of_run = !has_end;

    rec_end             = '0;
    rec_end.record_kind = lhp_pkg::KIND_END;
    rec_end.status      = end_status;
    rec_end.last_of_run = 1'b1;
    if (end_status == lhp_pkg::ST_OK) begin
      rec_end.version        = fixed_d[15:12];
      rec_end.psi_bits       = fixed_d[11:10];
      rec_end.close_flags    = fixed_d[9:8];
      rec_end.code_point     = fixed_d[7:0];
      rec_end.session_id     = sess_acc_d;
      rec_end.object_id_low  = obj_low_d;
      rec_end.object_id_high = obj_high_d;
    end

    push_o.push0 = item_valid_i && (has_byte || has_end);
    push_o.push1 = item_valid_i && has_byte && has_end;
    push_o.rec0  = has_byte ? rec_byte : rec_end;
    push_o.rec1  = rec_end;

    // packet over: start the next one from a clean slate
    if (item_i.packet_end) begin
      phase_d      = PH_WORD;
      byte_index_d = '0;
      header_d     = '0;
      cci_d        = '0;
      session_d    = '0;
      object_d     = '0;
      sess_acc_d   = '0;
      obj_low_d    = '0;
      obj_high_d   = '0;
      ext_type_d   = '0;
      ext_rem_d    = '0;
      fixed_d      = '0;
      need_len_d   = 1'b0;
      err_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WORD;
      byte_index_q <= '0;
      header_q     <= '0;
      cci_q        <= '0;
      session_q    <= '0;
      object_q     <= '0;
      sess_acc_q   <= '0;
      obj_low_q    <= '0;
      obj_high_q   <= '0;
      ext_type_q   <= '0;
      ext_rem_q    <= '0;
      fixed_q      <= '0;
      need_len_q   <= 1'b0;
      err_q        <= '0;
    end else if (item_valid_i) begin
      phase_q      <= phase_d;
      byte_index_q <= byte_index_d;
      header_q     <= header_d;
      cci_q        <= cci_d;
      session_q    <= session_d;
      object_q     <= object_d;
      sess_acc_q   <= sess_acc_d;
      obj_low_q    <= obj_low_d;
      obj_high_q   <= obj_high_d;
      ext_type_q   <= ext_type_d;
      ext_rem_q    <= ext_rem_d;
      fixed_q      <= fixed_d;
      need_len_q   <= need_len_d;
      err_q        <= err_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lhp_outq.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhp_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lhp_pkg::lhp_push_t push_i,
  output logic                    space_ok_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lhp_pkg::lhp_out_t       out_data_o
);

  lhp_pkg::lhp_out_t mem_q [lhp_pkg::OQ_DEPTH];

  logic [lhp_pkg::OQ_AW-1:0] wr_ptr_q, wr_ptr_d, wr_next, rd_ptr_q, rd_ptr_d;
  logic [lhp_pkg::OQ_CW-1:0] count_q, count_d;
  logic                      pop;

  assign wr_next     = wr_ptr_q + lhp_pkg::OQ_AW'(1);
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for the worst case of two results from one byte
  assign space_ok_o  = (count_q <= lhp_pkg::OQ_CW'(lhp_pkg::OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + lhp_pkg::OQ_AW'(push_i.push0) + lhp_pkg::OQ_AW'(push_i.push1);
    rd_ptr_d = rd_ptr_q + lhp_pkg::OQ_AW'(pop);
    count_d  = count_q + lhp_pkg::OQ_CW'(push_i.push0) + lhp_pkg::OQ_CW'(push_i.push1)
               - lhp_pkg::OQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wr_ptr_q] <= push_i.rec0;
    if (push_i.push1) mem_q[wr_next]  <= push_i.rec1;
  end

endmodule

`default_nettype wire

/* rtl/core/lhp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire lhp_pkg::lhp_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire lhp_pkg::lhp_out_t out_data_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a stalled input beat stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // input only backs up behind queued results
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a run that is not finished is followed at once by its end record
  a_run_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run
    |=> out_valid_o && out_data_o.record_kind == lhp_pkg::KIND_END)
    else $error("byte record not followed by end record");

  // byte records never carry a status
  a_byte_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind != lhp_pkg::KIND_END
    |-> out_data_o.status == lhp_pkg::ST_OK)
    else $error("status on a byte record");

endmodule

bind lct_header_parser lhp_checker u_lhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/lct_header_parser_tb.sv */
`timescale 1ns / 1ps

module lct_header_parser_tb;

  typedef enum logic [2:0] {
    PS_WAIT, PS_WORD, PS_CCI, PS_TSI, PS_TOI, PS_EXT, PS_DONE, PS_SKIP
  } parse_state_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  lhp_pkg::lhp_in_t  in_data   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  lhp_pkg::lhp_out_t out_data;

  // stimulus controls, written only by the test sequence
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_req   = 0;
  int hold_len   = 0;
  // receiver hold-off bookkeeping, written only by the stall process
  int hold_seen  = 0;
  int hold_left  = 0;

  int err_count  = 0;

  // header state of the parser as predicted
  parse_state_e lp_state = PS_WAIT;
  int           lp_idx, lp_hdr, lp_cci, lp_tsi_n, lp_toi_n, lp_ext_left;
  logic [47:0]  lp_tsi, lp_toi_hi;
  logic [63:0]  lp_toi_lo;
  logic [7:0]   lp_ext_type, lp_cp;
  logic [3:0]   lp_ver;
  logic [1:0]   lp_psi, lp_close, lp_err;
  bit           lp_need_len;

  lhp_pkg::lhp_out_t expected_records[$];

  lct_header_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("lct_header_parser_tb: errors");
    $finish;
  end

  function automatic void lp_new_packet();
    lp_idx      = 0;
    lp_hdr      = 0;
    lp_cci      = 0;
    lp_tsi_n    = 0;
    lp_toi_n    = 0;
    lp_ext_left = 0;
    lp_tsi      = '0;
    lp_toi_hi   = '0;
    lp_toi_lo   = '0;
    lp_ext_type = '0;
    lp_cp       = '0;
    lp_ver      = '0;
    lp_psi      = '0;
    lp_close    = '0;
    lp_err      = lhp_pkg::ST_OK;
    lp_need_len = 1'b0;
  endfunction

  function automatic lhp_pkg::lhp_out_t byte_record(logic [1:0] kind, logic [7:0] b,
                                                    logic [7:0] ty);
    lhp_pkg::lhp_out_t r;
    r = '0;
    r.record_kind = kind;
    r.out_byte    = b;
    r.ext_type    = ty;
    return r;
  endfunction

  function automatic lhp_pkg::lhp_out_t end_record(logic [1:0] st);
    lhp_pkg::lhp_out_t r;
    r = '0;
    r.record_kind = lhp_pkg::KIND_END;
    r.status      = st;
    if (st == lhp_pkg::ST_OK) begin
      r.version        = lp_ver;
      r.psi_bits       = lp_psi;
      r.code_point     = lp_cp;
      r.session_id     = lp_tsi;
      r.object_id_low  = lp_toi_lo;
      r.object_id_high = lp_toi_hi;
      r.close_flags    = lp_close;
    end
    return r;
  endfunction

  // returns 1 when the header is complete at this byte
  function automatic bit lp_enter_ext();
    lp_ext_left = 0;
    lp_need_len = 1'b0;
    if (lp_idx >= lp_hdr) begin
      lp_state = PS_DONE;
      return 1'b1;
    end
    lp_state = PS_EXT;
    return 1'b0;
  endfunction

  function automatic bit lp_next_field();
    if (lp_tsi_n != 0) begin
      lp_state = PS_TSI;
      return 1'b0;
    end
    if (lp_toi_n != 0) begin
      lp_state = PS_TOI;
      return 1'b0;
    end
    return lp_enter_ext();
  endfunction

  function automatic int field_words(logic [7:0] b0, logic [7:0] b1);
    return 1 + (int'(b0[3:2]) + 1) + int'(b1[7]) + int'(b1[6:5]) + int'(b1[4]);
  endfunction

  task automatic predict_records(input logic [7:0] b, input logic eop);
    lhp_pkg::lhp_out_t recs[$];
    bit                hdr_done;
    int                hel, left;
    hdr_done = 1'b0;
    if (lp_state == PS_WAIT) begin
      lp_new_packet();
      lp_state = PS_WORD;
    end
    if (lp_idx < 1023) lp_idx++;
    case (lp_state)
      PS_WORD: begin
        if (lp_idx == 1) begin
          lp_ver = b[7:4];
          lp_psi = b[1:0];
          lp_cci = 4 * (int'(b[3:2]) + 1);
        end else if (lp_idx == 2) begin
          lp_tsi_n = 4 * int'(b[7]) + 2 * int'(b[4]);
          lp_toi_n = 4 * int'(b[6:5]) + 2 * int'(b[4]);
          lp_close = b[1:0];
        end else if (lp_idx == 3) begin
          lp_hdr = 4 * int'(b);
        end else begin
          lp_cp = b;
          if (lp_hdr < 4 + lp_cci + lp_tsi_n + lp_toi_n) begin
            lp_err   = lhp_pkg::ST_OVERFLOW;
            lp_state = PS_SKIP;
          end else begin
            lp_state = PS_CCI;
          end
        end
      end
      PS_CCI: begin
        recs.push_back(byte_record(lhp_pkg::KIND_CCI, b, 8'h00));
        lp_cci--;
        if (lp_cci == 0) hdr_done = lp_next_field();
      end
      PS_TSI: begin
        lp_tsi = {lp_tsi[39:0], b};
        lp_tsi_n--;
        if (lp_tsi_n == 0) hdr_done = lp_next_field();
      end
      PS_TOI: begin
        lp_toi_hi = {lp_toi_hi[39:0], lp_toi_lo[63:56]};
        lp_toi_lo = {lp_toi_lo[55:0], b};
        lp_toi_n--;
        if (lp_toi_n == 0) hdr_done = lp_enter_ext();
      end
      PS_EXT: begin
        if (lp_need_len) begin
          hel  = 4 * int'(b);
          left = lp_hdr + 2 - lp_idx;
          lp_need_len = 1'b0;
          // a zero length would never advance, so it counts as an overrun
          if (hel == 0 || hel > left) begin
            lp_err   = lhp_pkg::ST_OVERRUN;
            lp_state = PS_SKIP;
          end else begin
            lp_ext_left = hel - 2;
          end
        end else if (lp_ext_left == 0) begin
          lp_ext_type = b;
          if (b >= lhp_pkg::EXT_FIXED_MIN) lp_ext_left = int'(lhp_pkg::EXT_FIXED_LEN);
          else lp_need_len = 1'b1;
        end else begin
          lp_ext_left--;
          recs.push_back(byte_record(lp_ext_left == 0 ? lhp_pkg::KIND_EXT_LAST
                                                      : lhp_pkg::KIND_EXT,
                                     b, lp_ext_type));
          if (lp_ext_left == 0 && lp_idx >= lp_hdr) begin
            lp_state = PS_DONE;
            hdr_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (hdr_done) recs.push_back(end_record(lhp_pkg::ST_OK));
    if (eop) begin
      if (lp_state == PS_SKIP)
        recs.push_back(end_record((lp_idx < 4 || lp_idx < lp_hdr) ? lhp_pkg::ST_SHORT
                                                                   : lp_err));
      else if (lp_state != PS_DONE)
        recs.push_back(end_record(lhp_pkg::ST_SHORT));
      lp_state = PS_WAIT;
    end
    if (recs.size() > 0) recs[recs.size() - 1].last_of_run = 1'b1;
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endtask

  function automatic string rec_text(lhp_pkg::lhp_out_t r);
    return $sformatf({"kind=%0d byte=%02h type=%02h ver=%0d psi=%0d cp=%02h tsi=%012h ",
                      "toi=%012h_%016h close=%0d st=%0d last=%0b"},
                     r.record_kind, r.out_byte, r.ext_type, r.version, r.psi_bits,
                     r.code_point, r.session_id, r.object_id_high, r.object_id_low,
                     r.close_flags, r.status, r.last_of_run);
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  // receiver side: short random stalls, plus a counted hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(99) < 7) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lhp_pkg::lhp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        note_error($sformatf("unexpected record: %s", rec_text(out_data)));
      end else begin
        want = expected_records.pop_front();
        if (out_data !== want)
          note_error($sformatf("record mismatch\n  exp %s\n  got %s",
                               rec_text(want), rec_text(out_data)));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eop);
    if (tx_idle_en && $urandom_range(99) < 5) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, packet_end: eop};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_records(b, eop);
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // well-formed header with random content; fill_max stretches it to HDR_LEN 255
  task automatic build_packet(output logic [7:0] pkt[$], input int n_ext, input bit fill_max);
    logic [7:0] ext_area[$];
    logic [7:0] b0, b1;
    int         words, hel;
    b0    = 8'($urandom);
    b1    = 8'($urandom);
    words = field_words(b0, b1);
    if (fill_max) begin
      hel = 255 - words;
      ext_area.push_back(8'($urandom_range(0, 127)));
      ext_area.push_back(8'(hel));
      repeat (4 * hel - 2) ext_area.push_back(8'($urandom));
    end else begin
      repeat (n_ext) begin
        if ($urandom_range(1) == 1) begin
          ext_area.push_back(8'($urandom_range(128, 255)));
          repeat (3) ext_area.push_back(8'($urandom));
        end else begin
          hel = $urandom_range(1, 3);
          ext_area.push_back(8'($urandom_range(0, 127)));
          ext_area.push_back(8'(hel));
          repeat (4 * hel - 2) ext_area.push_back(8'($urandom));
        end
      end
    end
    pkt = {};
    pkt.push_back(b0);
    pkt.push_back(b1);
    pkt.push_back(8'(words + ext_area.size() / 4));
    pkt.push_back(8'($urandom));
    repeat (4 * words - 4) pkt.push_back(8'($urandom));
    foreach (ext_area[i]) pkt.push_back(ext_area[i]);
  endtask

  task automatic test_header_extremes();
    logic [7:0] pkt[$];
    // all-zero minimal header, then one trailing payload byte
    send_packet({8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    // every flag set: 48-bit TSI, 112-bit TOI, one fixed extension of type 255
    pkt = {8'hF3, 8'hFF, 8'h08, 8'hFF};
    repeat (28) pkt.push_back(8'hFF);
    send_packet(pkt);
  endtask

  task automatic test_error_cases();
    // packet ends inside the first word
    send_packet({8'hA5, 8'h5A, 8'h05});
    // zero header length, fields cannot fit
    send_packet({8'h10, 8'h00, 8'h00, 8'h80});
    // variable extension with zero length, packet runs to the header end
    send_packet({8'h00, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                 8'h05, 8'h00, 8'h11, 8'h22});
  endtask

  task automatic test_output_hold();
    logic [7:0] pkt[$];
    hold_len = 200;
    hold_req++;
    // many byte records per packet so the result queue fills and the input stalls
    repeat (4) begin
      build_packet(pkt, 3, 1'b0);
      pkt[0][3:2] = 2'b11;
      pkt[2] = pkt[2] + 8'd3;
      send_packet(pkt);
    end
  endtask

  task automatic test_streaming();
    logic [7:0] pkt[$];
    int         sent;
    sent       = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (sent < 150) begin
      build_packet(pkt, $urandom_range(0, 3), 1'b0);
      repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
      send_packet(pkt);
      sent += pkt.size();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] pkt[$];
    int         sent, mode, n, k, hel;
    sent = 0;
    while (sent < 250) begin
      mode = $urandom_range(99);
      build_packet(pkt, $urandom_range(0, 3), 1'b0);
      if (mode < 70) begin
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
      end else if (mode < 80) begin
        n   = $urandom_range(1, pkt.size());
        pkt = pkt[0:n-1];
      end else if (mode < 87) begin
        // header length shorter than the flagged fields
        pkt[2] = 8'($urandom_range(0, field_words(pkt[0], pkt[1]) - 1));
        n      = $urandom_range(4, pkt.size());
        pkt    = pkt[0:n-1];
      end else if (mode < 95) begin
        // extension length of zero or past the header end
        build_packet(pkt, 0, 1'b0);
        k      = $urandom_range(1, 2);
        pkt[2] = pkt[2] + 8'(k);
        hel    = ($urandom_range(1) == 1) ? 0 : $urandom_range(k + 1, 255);
        pkt.push_back(8'($urandom_range(0, 127)));
        pkt.push_back(8'(hel));
        repeat ($urandom_range(0, 4 * k + 2)) pkt.push_back(8'($urandom));
      end else begin
        pkt = {};
        repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom));
      end
      send_packet(pkt);
      sent += pkt.size();
    end
  endtask

  task automatic test_long_header();
    logic [7:0] pkt[$];
    // largest header, payload carries the byte count past its saturation point
    build_packet(pkt, 0, 1'b1);
    repeat (20) pkt.push_back(8'($urandom));
    send_packet(pkt);
  endtask

  initial begin
    int n;
    lp_new_packet();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_header_extremes();
    test_error_cases();
    test_output_hold();
    test_streaming();
    test_random_traffic();
    test_long_header();

    in_valid <= 1'b0;
    n = 0;
    while (expected_records.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (expected_records.size() != 0)
      note_error($sformatf("%0d records never arrived", expected_records.size()));

    if (err_count == 0) begin
      $display("lct_header_parser_tb: clean");
    end else begin
      $display("lct_header_parser_tb: errors");
    end
    $finish;
  end

endmodule

/* lct_header_parser.f */
rtl/core/lhp_pkg.sv
rtl/core/lhp_parse.sv
rtl/core/lhp_outq.sv
rtl/core/lct_header_parser.sv
rtl/core/lhp_checker.sv
tb/lct_header_parser_tb.sv
